// ----- sv/rxsa_pkg.sv -----
// ---------------------------------------------------------------------------
// rxsa_pkg
// shared constants and types for the range xor / sort array
// ---------------------------------------------------------------------------
package rxsa_pkg;
    localparam int DEPTH      = 1024;
    localparam int VALUE_BITS = 31;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS   = ADDR_BITS + 1;
    localparam int CFG_BITS   = 11;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_XOR   = 2'd1;
    localparam logic [1:0] FUNC_SORT  = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [ADDR_BITS-1:0]  t_addr;
endpackage

// ----- sv/rxsa_ram.sv -----
// ---------------------------------------------------------------------------
// rxsa_ram
// generic single-port-write, one-read ram with registered read data
// ---------------------------------------------------------------------------
module rxsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/range_xor_sort_array.sv -----
// ---------------------------------------------------------------------------
// range_xor_sort_array
// element array with load, range xor, range sort and range xor query
// ---------------------------------------------------------------------------
// One item at a time through a ram with one write and one read port;
// busy stays high until the item is done. Load writes one element. Range
// xor reads and writes back each element of the clipped span; query reads
// and accumulates each one. Range sort is an in-place selection sort of
// the span: a read and compare pass for each position, then the swap
// states SW1, SW2 and SW3. An empty span goes straight to the done state.
// A query result shows for one cycle on o_xor_sum with o_xor_valid; the
// receiver cannot stall it. The ram needs no clearing after reset.
// ---------------------------------------------------------------------------
module range_xor_sort_array (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_func,
    input  logic [rxsa_pkg::ADDR_BITS-1:0]  i_lo,
    input  logic [rxsa_pkg::ADDR_BITS-1:0]  i_hi,
    input  logic [rxsa_pkg::VALUE_BITS-1:0] i_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rxsa_pkg::CFG_BITS-1:0]   cfg_data,
    output logic                            o_xor_valid,
    output logic [rxsa_pkg::VALUE_BITS-1:0] o_xor_sum
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_XRD   = 4'd1;
    localparam logic [3:0] S_XWR   = 4'd2;
    localparam logic [3:0] S_QRD   = 4'd3;
    localparam logic [3:0] S_QACC  = 4'd4;
    localparam logic [3:0] S_MINRD = 4'd5;
    localparam logic [3:0] S_MINCK = 4'd6;
    localparam logic [3:0] S_SW1   = 4'd7;
    localparam logic [3:0] S_SW2   = 4'd8;
    localparam logic [3:0] S_SW3   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]                    r_state, n_state;
    logic [rxsa_pkg::CFG_BITS-1:0] r_count;
    rxsa_pkg::t_addr               r_hi, r_i, r_j, r_min_idx;
    rxsa_pkg::t_value              r_val, r_acc, r_min;
    logic                          r_first;

    logic                          we;
    rxsa_pkg::t_addr               waddr, raddr;
    rxsa_pkg::t_value              wdata, rdata;

    logic [rxsa_pkg::CFG_BITS-1:0] in_use, hi_cl;
    logic                          empty, go;

    rxsa_ram #(.WIDTH(rxsa_pkg::VALUE_BITS), .DEPTH(rxsa_pkg::DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign busy      = (r_state != S_IDLE);
    assign cfg_ready = !busy;
    assign go        = start && !busy;

    always_comb begin
        in_use = (r_count > rxsa_pkg::CFG_BITS'(rxsa_pkg::DEPTH))
            ? rxsa_pkg::CFG_BITS'(rxsa_pkg::DEPTH) : r_count;
        hi_cl = rxsa_pkg::CFG_BITS'(i_hi);
        if (in_use != '0 && hi_cl > in_use - 1'b1) begin
            hi_cl = in_use - 1'b1;
        end
        empty = (in_use == '0) || (rxsa_pkg::CFG_BITS'(i_lo) > hi_cl);
    end

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        waddr   = r_i;
        wdata   = r_val;
        raddr   = r_i;
        unique case (r_state)
            S_IDLE: begin
                waddr = i_lo;
                wdata = i_value;
                if (go) begin
                    unique case (i_func)
                        rxsa_pkg::FUNC_LOAD: begin
                            we = rxsa_pkg::CFG_BITS'(i_lo) < in_use;
                            n_state = S_DONE;
                        end
                        rxsa_pkg::FUNC_XOR:   n_state = empty ? S_DONE : S_XRD;
                        rxsa_pkg::FUNC_SORT:  n_state = empty ? S_DONE : S_MINRD;
                        rxsa_pkg::FUNC_QUERY: n_state = empty ? S_DONE : S_QRD;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_XRD: n_state = S_XWR;
            S_XWR: begin
                we      = 1'b1;
                wdata   = rdata ^ r_val;
                n_state = (r_i == r_hi) ? S_DONE : S_XRD;
            end
            S_QRD:  n_state = S_QACC;
            S_QACC: n_state = (r_i == r_hi) ? S_DONE : S_QRD;
            S_MINRD: begin
                raddr   = r_j;
                n_state = S_MINCK;
            end
            S_MINCK: begin
                raddr   = r_j;
                n_state = (r_j == r_hi) ? S_SW1 : S_MINRD;
            end
            S_SW1: n_state = S_SW2;
            S_SW2: begin
                we      = (r_min_idx != r_i);
                waddr   = r_min_idx;
                wdata   = rdata;
                n_state = S_SW3;
            end
            S_SW3: begin
                we      = 1'b1;
                wdata   = r_min;
                n_state = (r_i == r_hi) ? S_DONE : S_MINRD;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= rxsa_pkg::CFG_BITS'(1024);
            o_xor_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_xor_valid <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                r_count <= cfg_data;
            end
            if (go && i_func == rxsa_pkg::FUNC_QUERY && empty) begin
                o_xor_valid <= 1'b1;
            end
            if (r_state == S_QACC && r_i == r_hi) begin
                o_xor_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_hi    <= hi_cl[rxsa_pkg::ADDR_BITS-1:0];
                r_i     <= i_lo;
                r_j     <= i_lo;
                r_val   <= i_value;
                r_acc   <= '0;
                r_first <= 1'b1;
                o_xor_sum <= '0;
            end
            S_XWR: r_i <= r_i + 1'b1;
            S_QACC: begin
                r_acc     <= r_acc ^ rdata;
                o_xor_sum <= r_acc ^ rdata;
                r_i       <= r_i + 1'b1;
            end
            S_MINCK: begin
                if (r_first || rdata < r_min) begin
                    r_min     <= rdata;
                    r_min_idx <= r_j;
                end
                r_first <= 1'b0;
                r_j     <= r_j + 1'b1;
            end
            S_SW3: begin
                r_i     <= r_i + 1'b1;
                r_j     <= r_i + 1'b1;
                r_first <= 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ----- bench/range_xor_sort_array_tb.sv -----
// ---------------------------------------------------------------------------
// range_xor_sort_array_tb
// self-checking bench for the range xor / sort array
// ---------------------------------------------------------------------------
// Fills the first 256 elements, runs a short directed list over the edge
// cases (full, single and empty spans, clipping, ignored loads, extreme
// values), then random phases at many element counts up to 256. A shadow
// array predicts every query sum; results are compared in order as they
// strobe out.
// ---------------------------------------------------------------------------
module range_xor_sort_array_tb;
    localparam int FILL = 256;

    typedef enum logic [1:0] {E_OP, E_CFG, E_DRAIN} t_kind;
    typedef struct {
        t_kind                         kind;
        logic [1:0]                    func;
        rxsa_pkg::t_addr               lo;
        rxsa_pkg::t_addr               hi;
        rxsa_pkg::t_value              value;
        logic [rxsa_pkg::CFG_BITS-1:0] cnt;
    } t_entry;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    i_func = rxsa_pkg::FUNC_LOAD;
    rxsa_pkg::t_addr               i_lo = '0;
    rxsa_pkg::t_addr               i_hi = '0;
    rxsa_pkg::t_value              i_value = '0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rxsa_pkg::CFG_BITS-1:0] cfg_data = '0;
    logic                          o_xor_valid;
    rxsa_pkg::t_value              o_xor_sum;

    t_entry           pending[$];
    t_entry           cur;
    rxsa_pkg::t_value xor_due[$];
    rxsa_pkg::t_value elem_shadow[rxsa_pkg::DEPTH];
    int               count_shadow = rxsa_pkg::DEPTH;
    int               gap_left = 0;
    int               burst_left = 0;
    int               quiet = 0;
    int               errors = 0;
    int               n_items = 0;
    int               n_cfg = 0;
    int               n_sums = 0;
    bit               run_start;
    bit               run_cfg;

    range_xor_sort_array uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_lo        (i_lo),
        .i_hi        (i_hi),
        .i_value     (i_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .o_xor_valid (o_xor_valid),
        .o_xor_sum   (o_xor_sum)
    );

    always #6 i_clk = ~i_clk;

    function void apply_item(t_entry e);
        int               n, top, a, b;
        rxsa_pkg::t_value acc, tmp;
        n = (count_shadow > rxsa_pkg::DEPTH) ? rxsa_pkg::DEPTH : count_shadow;
        if (e.func == rxsa_pkg::FUNC_LOAD) begin
            if (int'(e.lo) < n)
                elem_shadow[e.lo] = e.value;
            return;
        end
        top = (n == 0) ? -1 : ((int'(e.hi) > n - 1) ? n - 1 : int'(e.hi));
        acc = '0;
        if (e.func == rxsa_pkg::FUNC_SORT) begin
            for (a = int'(e.lo) + 1; a <= top; a++) begin
                tmp = elem_shadow[a];
                b = a - 1;
                while (b >= int'(e.lo) && elem_shadow[b] > tmp) begin
                    elem_shadow[b+1] = elem_shadow[b];
                    b--;
                end
                elem_shadow[b+1] = tmp;
            end
        end else begin
            for (a = int'(e.lo); a <= top; a++) begin
                if (e.func == rxsa_pkg::FUNC_XOR)
                    elem_shadow[a] = elem_shadow[a] ^ e.value;
                else
                    acc = acc ^ elem_shadow[a];
            end
            if (e.func == rxsa_pkg::FUNC_QUERY)
                xor_due.push_back(acc);
        end
    endfunction

    function int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    task add_op(logic [1:0] f, int lo, int hi, rxsa_pkg::t_value v);
        t_entry e;
        e.kind = E_OP;
        e.func = f;
        e.lo = rxsa_pkg::t_addr'(lo);
        e.hi = rxsa_pkg::t_addr'(hi);
        e.value = v;
        e.cnt = '0;
        pending.push_back(e);
    endtask

    task add_ctl(t_kind k, int c);
        t_entry e;
        e.kind = k;
        e.func = rxsa_pkg::FUNC_LOAD;
        e.lo = '0;
        e.hi = '0;
        e.value = '0;
        e.cnt = rxsa_pkg::CFG_BITS'(c);
        pending.push_back(e);
    endtask

    task rand_phase(int c, int n);
        int               k, r, lo, hi, maxlen;
        logic [1:0]       f;
        rxsa_pkg::t_value v;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            f = (r < 20) ? rxsa_pkg::FUNC_LOAD
              : (r < 45) ? rxsa_pkg::FUNC_XOR
              : (r < 60) ? rxsa_pkg::FUNC_SORT : rxsa_pkg::FUNC_QUERY;
            lo = $urandom_range(0, (c > rxsa_pkg::DEPTH ? rxsa_pkg::DEPTH : c) - 1);
            if ($urandom_range(0, 9) == 0)
                lo = $urandom_range(0, rxsa_pkg::DEPTH - 1);
            maxlen = (c <= 64) ? c : ((f == rxsa_pkg::FUNC_SORT) ? 31 : c);
            hi = lo + $urandom_range(0, maxlen);
            if ($urandom_range(0, 9) == 0 && (f != rxsa_pkg::FUNC_SORT || c <= 64))
                hi = $urandom_range(0, rxsa_pkg::DEPTH - 1);
            if (hi > rxsa_pkg::DEPTH - 1)
                hi = rxsa_pkg::DEPTH - 1;
            case ($urandom_range(0, 7))
                0: v = '0;
                1: v = '1;
                default: v = rxsa_pkg::t_value'($urandom);
            endcase
            add_op(f, lo, hi, v);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left = 0;
            quiet = 0;
        end else begin
            run_start = start;
            run_cfg = cfg_valid;
            if (start && !busy) begin
                apply_item(cur);
                n_items++;
                run_start = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                count_shadow = int'(cfg_data);
                n_cfg++;
                run_cfg = 1'b0;
            end
            quiet = (busy || start) ? 0 : quiet + 1;
            if (!run_start && !run_cfg && pending.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending[0].kind == E_OP) begin
                    cur = pending.pop_front();
                    i_func <= cur.func;
                    i_lo <= cur.lo;
                    i_hi <= cur.hi;
                    i_value <= cur.value;
                    run_start = 1'b1;
                    gap_left = draw_gap();
                end else if (xor_due.size() == 0 && quiet >= 4) begin
                    if (pending[0].kind == E_CFG) begin
                        cfg_data <= pending[0].cnt;
                        run_cfg = 1'b1;
                    end
                    pending.delete(0);
                end
            end
            start <= run_start;
            cfg_valid <= run_cfg;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_xor_valid) begin
            n_sums++;
            if (xor_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected xor_sum %h", o_xor_sum);
            end else if (o_xor_sum !== xor_due[0]) begin
                errors++;
                if (errors <= 10)
                    $display("xor_sum mismatch: expected %h got %h", xor_due[0], o_xor_sum);
                xor_due.delete(0);
            end else begin
                xor_due.delete(0);
            end
        end
    end

    initial begin
        int k;
        int plan[10] = '{1, 256, 16, 200, 3, 64, 250, 2, 128, 33};
        for (k = 0; k < FILL; k++)
            add_op(rxsa_pkg::FUNC_LOAD, k, $urandom_range(0, rxsa_pkg::DEPTH - 1),
                   (k % 97 == 0) ? '1 : rxsa_pkg::t_value'($urandom));
        add_ctl(E_CFG, FILL);
        // directed edge cases
        add_op(rxsa_pkg::FUNC_QUERY, 0, 1023, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 5, 5, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 7, 3, '0);
        add_op(rxsa_pkg::FUNC_LOAD, 0, 0, '0);
        add_op(rxsa_pkg::FUNC_LOAD, 1023, 0, '1);
        add_op(rxsa_pkg::FUNC_XOR, 0, 9, '1);
        add_op(rxsa_pkg::FUNC_XOR, 10, 10, '0);
        add_op(rxsa_pkg::FUNC_SORT, 0, 15, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 0, 15, '0);
        add_op(rxsa_pkg::FUNC_SORT, 200, 1023, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 200, 1023, '0);
        add_op(rxsa_pkg::FUNC_SORT, 9, 2, '0);
        add_op(rxsa_pkg::FUNC_XOR, 9, 2, '1);
        add_ctl(E_CFG, 20);
        add_op(rxsa_pkg::FUNC_QUERY, 0, 1023, '0);
        add_op(rxsa_pkg::FUNC_LOAD, 25, 0, '1);
        add_op(rxsa_pkg::FUNC_SORT, 5, 1023, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 1023, 1023, '0);
        add_op(rxsa_pkg::FUNC_XOR, 15, 1023, rxsa_pkg::t_value'($urandom));
        add_op(rxsa_pkg::FUNC_QUERY, 10, 1023, '0);
        add_ctl(E_CFG, 1);
        add_op(rxsa_pkg::FUNC_LOAD, 1, 0, '1);
        add_op(rxsa_pkg::FUNC_SORT, 0, 1023, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 0, 1023, '0);
        add_ctl(E_CFG, FILL);
        add_op(rxsa_pkg::FUNC_SORT, 0, FILL - 1, '0);
        add_op(rxsa_pkg::FUNC_QUERY, 0, FILL - 1, '0);
        // random phases across element counts
        foreach (plan[k]) begin
            add_ctl(E_CFG, plan[k]);
            rand_phase(plan[k], 15);
            add_ctl(E_DRAIN, 0);
            rand_phase(plan[k], 15);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending.size() != 0 || start || cfg_valid) @(posedge i_clk);
        while (xor_due.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (xor_due.size() != 0) begin
            errors += xor_due.size();
            $display("%0d xor sums never arrived", xor_due.size());
        end
        $display("ran %0d items over %0d element-count settings", n_items, n_cfg);
        $display("checked %0d query sums, %0d mismatches", n_sums, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("DONE: errors detected");
        $finish;
    end
endmodule
